[hdl/lzwc_pkg.sv]
// shared constants for the lzw byte compressor
`default_nettype none
package lzwc_pkg;
   localparam int DICT_ENTRIES_DEF = 4096;
   localparam int FIRST_FREE       = 256;
   localparam int BYTE_W           = 8;
   localparam int OUT_CODE_W       = 12;
endpackage
`default_nettype wire

[hdl/lzwc_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module lzwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[hdl/lzwc_ctrl.sv]
// byte sequencer: trie walk over head and entry memories, insert, result register
`default_nettype none
module lzwc_ctrl #(
   parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire logic [lzwc_pkg::BYTE_W-1:0]                req_data_byte,
   input  wire logic                                       req_final_byte,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic      [lzwc_pkg::OUT_CODE_W-1:0]            rsp_out_code,
   output logic                                            rsp_last_code,
   output logic                                            head_rd_en,
   output logic      [$clog2(DICT_ENTRIES)-1:0]            head_rd_addr,
   input  wire logic [$clog2(DICT_ENTRIES)-1:0]            head_rd_data,
   output logic                                            head_wr_en,
   output logic      [$clog2(DICT_ENTRIES)-1:0]            head_wr_addr,
   output logic      [$clog2(DICT_ENTRIES)-1:0]            head_wr_data,
   output logic                                            ent_rd_en,
   output logic      [$clog2(DICT_ENTRIES-lzwc_pkg::FIRST_FREE)-1:0] ent_rd_addr,
   input  wire logic [2*$clog2(DICT_ENTRIES)+lzwc_pkg::BYTE_W-1:0] ent_rd_data,
   output logic                                            ent_wr_en,
   output logic      [$clog2(DICT_ENTRIES-lzwc_pkg::FIRST_FREE)-1:0] ent_wr_addr,
   output logic      [2*$clog2(DICT_ENTRIES)+lzwc_pkg::BYTE_W-1:0] ent_wr_data
);
   import lzwc_pkg::*;

   localparam int CW = $clog2(DICT_ENTRIES);
   localparam int EW = $clog2(DICT_ENTRIES - FIRST_FREE);
   localparam logic [CW-1:0] FIRST_CODE = CW'(FIRST_FREE);
   localparam logic [CW:0]   FIRST_NF   = (CW+1)'(FIRST_FREE);
   localparam logic [CW:0]   DICT_CODE  = (CW+1)'(DICT_ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HEAD = 5'b00010,
      S_NODE = 5'b00100,
      S_MISS = 5'b01000,
      S_LAST = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic                  fin_ff, fin_in;
   logic [CW-1:0]         cur_ff, cur_in;
   logic                  pv_ff, pv_in;
   logic [CW:0]           nf_ff, nf_in;
   logic [CW-1:0]         head_ff, head_in;
   logic [CW-1:0]         node_ff, node_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  rsp_free;
   logic                  rsp_load;
   logic [CW-1:0]         e_pre;
   logic [BYTE_W-1:0]     e_suf;
   logic [CW-1:0]         e_sib;
   logic [CW+OUT_CODE_W-1:0] code_wide;
   logic [CW-1:0]         nf_slot;

   // an entry pointer is trusted only inside the codes assigned in this stream
   function automatic logic code_live(input logic [CW-1:0] v, input logic [CW:0] nf);
      code_live = (v >= FIRST_CODE) && ({1'b0, v} < nf);
   endfunction

   function automatic logic [EW-1:0] ent_addr(input logic [CW-1:0] v);
      logic [CW-1:0] off;
      off = v - FIRST_CODE;
      ent_addr = off[EW-1:0];
   endfunction

   assign {e_pre, e_suf, e_sib} = ent_rd_data;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign code_wide = {{OUT_CODE_W{1'b0}}, cur_ff};
   assign nf_slot   = nf_ff[CW-1:0];

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      fin_in       = fin_ff;
      cur_in       = cur_ff;
      pv_in        = pv_ff;
      nf_in        = nf_ff;
      head_in      = head_ff;
      node_in      = node_ff;
      rsp_load     = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_code_in  = rsp_code_ff;
      head_rd_en   = 1'b0;
      head_rd_addr = cur_ff;
      head_wr_en   = 1'b0;
      head_wr_addr = cur_ff;
      head_wr_data = nf_slot;
      ent_rd_en    = 1'b0;
      ent_rd_addr  = ent_addr(head_rd_data);
      ent_wr_en    = 1'b0;
      ent_wr_addr  = ent_addr(nf_slot);
      ent_wr_data  = {cur_ff, byte_ff, head_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               fin_in  = req_final_byte;
               if (!pv_ff) begin
                  cur_in   = {{(CW-BYTE_W){1'b0}}, req_data_byte};
                  pv_in    = 1'b1;
                  state_in = req_final_byte ? S_LAST : S_IDLE;
               end else begin
                  head_rd_en = 1'b1;
                  state_in   = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            head_in = head_rd_data;
            if (code_live(head_rd_data, nf_ff)) begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = ent_addr(head_rd_data);
               node_in     = head_rd_data;
               state_in    = S_NODE;
            end else begin
               state_in = S_MISS;
            end
         end
         S_NODE: begin
            if (e_pre == cur_ff) begin
               if (e_suf == byte_ff) begin
                  cur_in   = node_ff;
                  state_in = fin_ff ? S_LAST : S_IDLE;
               end else if (code_live(e_sib, nf_ff) && (e_sib < node_ff)) begin
                  // siblings run strictly downward, which also stops stale links
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = ent_addr(e_sib);
                  node_in     = e_sib;
               end else begin
                  state_in = S_MISS;
               end
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_code_in = code_wide[OUT_CODE_W-1:0];
               rsp_last_in = 1'b0;
               if (nf_ff < DICT_CODE) begin
                  head_wr_en = 1'b1;
                  ent_wr_en  = 1'b1;
                  nf_in      = nf_ff + 1'b1;
               end
               cur_in   = {{(CW-BYTE_W){1'b0}}, byte_ff};
               state_in = fin_ff ? S_LAST : S_IDLE;
            end
         end
         S_LAST: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_code_in = code_wide[OUT_CODE_W-1:0];
               rsp_last_in = 1'b1;
               nf_in       = FIRST_NF;
               pv_in       = 1'b0;
               cur_in      = '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         pv_ff        <= 1'b0;
         nf_ff        <= FIRST_NF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         pv_ff        <= pv_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      fin_ff      <= fin_in;
      head_ff     <= head_in;
      node_ff     <= node_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_code  = rsp_code_ff;
   assign rsp_last_code = rsp_last_ff;
endmodule
`default_nettype wire

[hdl/lzw_byte_compressor_core.sv]
// top level of the lzw byte compressor: sequencer plus head and entry memories
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_data_byte[7:0], req_final_byte
//  rsp      out        rsp_valid/stall    rsp_out_code[11:0], rsp_last_code
//
// a byte that hits on the first child in its trie list passes the idle, head and node states,
// plus one node probe per extra sibling visited; the entry memory read port sets this, one probe a cycle
// a miss after an entry probe adds the miss state to emit and write back; a head read with no
// child goes from the head state straight to the miss state; the final byte adds the last state for the last code
// reset is synchronous; the dictionary is dropped by resetting the free-code counter, no sweep
// a byte is taken while a result waits in the output register; rsp_stall only holds emits
`default_nettype none
module lzw_byte_compressor_core #(
   parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [lzwc_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic                            req_final_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [lzwc_pkg::OUT_CODE_W-1:0] rsp_out_code,
   output logic                                 rsp_last_code
);
   import lzwc_pkg::*;

   localparam int CW = $clog2(DICT_ENTRIES);
   localparam int EW = $clog2(DICT_ENTRIES - FIRST_FREE);
   localparam int ENT_W = 2 * CW + BYTE_W;

   logic            head_rd_en, head_wr_en;
   logic [CW-1:0]   head_rd_addr, head_rd_data, head_wr_addr, head_wr_data;
   logic            ent_rd_en, ent_wr_en;
   logic [EW-1:0]   ent_rd_addr, ent_wr_addr;
   logic [ENT_W-1:0] ent_rd_data, ent_wr_data;

   // newest child code of each prefix code
   lzwc_ram #(
      .WIDTH (CW),
      .DEPTH (DICT_ENTRIES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   // prefix, byte and older sibling of each assigned code
   lzwc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DICT_ENTRIES - FIRST_FREE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   lzwc_ctrl #(
      .DICT_ENTRIES (DICT_ENTRIES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_code   (rsp_out_code),
      .rsp_last_code  (rsp_last_code),
      .head_rd_en     (head_rd_en),
      .head_rd_addr   (head_rd_addr),
      .head_rd_data   (head_rd_data),
      .head_wr_en     (head_wr_en),
      .head_wr_addr   (head_wr_addr),
      .head_wr_data   (head_wr_data),
      .ent_rd_en      (ent_rd_en),
      .ent_rd_addr    (ent_rd_addr),
      .ent_rd_data    (ent_rd_data),
      .ent_wr_en      (ent_wr_en),
      .ent_wr_addr    (ent_wr_addr),
      .ent_wr_data    (ent_wr_data)
   );
endmodule
`default_nettype wire

[tb/sv/tb_lzw_byte_compressor_core.sv]
// testbench for the lzw byte compressor: byte streams checked against a code predictor
`default_nettype none
module tb_lzw_byte_compressor_core;
   import lzwc_pkg::*;

   // small dictionary so that one stream can fill it
   localparam int DICT_SIZE   = 512;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_WAIT  = 600;

   typedef struct packed {
      logic [OUT_CODE_W-1:0] code;
      logic                  is_last;
   } code_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  req_final_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [OUT_CODE_W-1:0] rsp_out_code;
   logic                  rsp_last_code;

   // predictor state: string code so far and the pair dictionary
   int                    dict_free_code;
   logic [OUT_CODE_W-1:0] string_code;
   bit                    string_open;
   int                    pair_code [bit [OUT_CODE_W+BYTE_W-1:0]];
   code_type              pending_codes [$];

   int err_count = 0;
   int cycle_count = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_request = 0;

   lzw_byte_compressor_core #(
      .DICT_ENTRIES (DICT_SIZE)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_code   (rsp_out_code),
      .rsp_last_code  (rsp_last_code)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL lzw_byte_compressor_core");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   function automatic void dict_clear();
      dict_free_code = FIRST_FREE;
      string_open    = 1'b0;
      string_code    = '0;
      pair_code.delete();
   endfunction

   function automatic void queue_code(input logic [OUT_CODE_W-1:0] c, input logic l);
      code_type item;
      item.code    = c;
      item.is_last = l;
      pending_codes.insert(pending_codes.size(), item);
   endfunction

   function automatic void compress_byte(logic [BYTE_W-1:0] b, logic fin);
      bit [OUT_CODE_W+BYTE_W-1:0] key;
      logic [OUT_CODE_W-1:0]      b_code;
      key    = {string_code, b};
      b_code = {{(OUT_CODE_W-BYTE_W){1'b0}}, b};
      if (!string_open) begin
         string_code = b_code;
         string_open = 1'b1;
      end else if (pair_code.exists(key)) begin
         string_code = OUT_CODE_W'(pair_code[key]);
      end else begin
         queue_code(string_code, 1'b0);
         if (dict_free_code < DICT_SIZE) begin
            pair_code[key] = dict_free_code;
            dict_free_code++;
         end
         string_code = b_code;
      end
      if (fin) begin
         queue_code(string_code, 1'b1);
         dict_clear();
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      code_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            $error("unexpected transaction: out_code %0d last_code %0b",
                   rsp_out_code, rsp_last_code);
            err_count++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_out_code !== want.code) begin
               $error("out_code: expected %0d, actual %0d", want.code, rsp_out_code);
               err_count++;
            end
            if (rsp_last_code !== want.is_last) begin
               $error("last_code: expected %0b, actual %0b", want.is_last, rsp_last_code);
               err_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      compress_byte(b, fin);
   endtask

   task automatic test_one_byte_streams();
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h5a, 1'b1);
   endtask

   // repeated bytes and alternating patterns build chains of hits
   task automatic test_repeat_patterns();
      for (int i = 0; i < 5; i++) send_byte(8'hff, i == 4);
      for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'h80 : 8'h00, i == 7);
      for (int i = 0; i < 5; i++) send_byte(i[0] ? 8'haa : 8'h55, i == 4);
   endtask

   task automatic test_random_streams(input int n_bytes);
      int sent;
      int len;
      int n_sym;
      bit full_range;
      logic [BYTE_W-1:0] alphabet [8];
      logic [BYTE_W-1:0] b;
      logic [2:0]        pick;
      sent = 0;
      while (sent < n_bytes) begin
         len        = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(60, 2));
         full_range = ($urandom_range(3) == 0);
         n_sym      = int'($urandom_range(8, 1));
         foreach (alphabet[k]) alphabet[k] = BYTE_W'($urandom_range(255));
         for (int i = 0; i < len; i++) begin
            pick = 3'($urandom_range(n_sym - 1));
            b    = full_range ? BYTE_W'($urandom_range(255)) : alphabet[pick];
            send_byte(b, i == len - 1);
            sent++;
         end
      end
   endtask

   // receiver holds off while bytes keep coming, so the block backs up
   task automatic test_backpressure();
      int saved_pct;
      saved_pct    = snd_idle_pct;
      snd_idle_pct = 0;
      hold_request = 400;
      for (int i = 0; i < 80; i++) send_byte(BYTE_W'($urandom_range(255)), i == 79);
      snd_idle_pct = saved_pct;
   endtask

   // one long stream that fills the dictionary, then keeps coding past full
   task automatic test_dictionary_full();
      int past_full;
      past_full = 0;
      while (past_full < 60) begin
         send_byte(BYTE_W'($urandom_range(255)), 1'b0);
         if (dict_free_code == DICT_SIZE) past_full++;
      end
      send_byte(BYTE_W'($urandom_range(255)), 1'b1);
      // a fresh stream right after must start from an empty dictionary
      for (int i = 0; i < 6; i++) send_byte(8'h41, i == 5);
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= '0;
      req_final_byte <= 1'b0;
      dict_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle_pct = 28;
      rcv_idle_pct = 63;
      test_one_byte_streams();
      test_repeat_patterns();
      test_random_streams(150);

      snd_idle_pct = 63;
      rcv_idle_pct = 28;
      test_random_streams(150);
      test_backpressure();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_streams(150);
      test_dictionary_full();

      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (err_count == 0) begin
         $display("PASS lzw_byte_compressor_core");
      end else begin
         $display("FAIL lzw_byte_compressor_core");
      end
      $finish;
   end
endmodule
`default_nettype wire
